[rtl/ute_pkg.sv]
package ute_pkg;

    // byte order mark halves
    localparam logic [7:0] BOM_FE = 8'hfe;
    localparam logic [7:0] BOM_FF = 8'hff;

    // utf-8 range limits and lead/continuation marks
    localparam logic [15:0] LIMIT_ONE  = 16'h0080;
    localparam logic [15:0] LIMIT_TWO  = 16'h0800;
    localparam logic [7:0]  LEAD_TWO   = 8'hc0;
    localparam logic [7:0]  LEAD_THREE = 8'he0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;
    localparam logic [5:0]  CONT_MASK  = 6'h3f;

    // source encoding codes
    localparam logic MODE_LATIN1 = 1'b0;
    localparam logic MODE_UCS2   = 1'b1;
    localparam logic MODE_RESET  = MODE_UCS2;

    // queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified request for the back end
    typedef struct packed {
        logic [15:0] unit;  // code unit to encode
        logic [1:0]  len;   // utf-8 bytes for the unit, 0 when none
        logic        term;  // terminating zero follows
    } t_job;

    // utf-8 length of a code unit
    function automatic logic [1:0] utf8_len(input logic [15:0] unit);
        logic [1:0] len;
        if (unit < LIMIT_ONE) begin
            len = 2'd1;
        end else if (unit < LIMIT_TWO) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    // utf-8 byte at position pos of a unit encoded in len bytes
    function automatic logic [7:0] utf8_byte(input logic [15:0] unit,
                                             input logic [1:0]  len,
                                             input logic [1:0]  pos);
        logic [7:0] b;
        b = CONT_MARK | {2'b00, unit[5:0] & CONT_MASK};
        case (len)
            2'd1: begin
                b = unit[7:0];
            end
            2'd2: begin
                if (pos == 2'd0) begin
                    b = LEAD_TWO | {3'b000, unit[10:6]};
                end
            end
            2'd3: begin
                if (pos == 2'd0) begin
                    b = LEAD_THREE | {4'b0000, unit[15:12]};
                end else if (pos == 2'd1) begin
                    b = CONT_MARK | {2'b00, unit[11:6]};
                end
            end
            default: begin
                b = 8'h00;
            end
        endcase
        return b;
    endfunction

endpackage

[rtl/ute_front.sv]
module ute_front import ute_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_queue_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_job       o_job
);

    logic       r_mode;
    logic [7:0] r_held;
    logic       r_half;
    logic       r_first;
    logic       r_big;

    logic       n_half;
    logic       n_first;
    logic       n_big;
    logic [7:0] n_held;
    logic       accept;
    t_job       job;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // classify the request and work out the next string state
    always_comb begin
        n_half   = r_half;
        n_first  = r_first;
        n_big    = r_big;
        n_held   = r_held;
        job.unit = 16'h0000;
        job.len  = 2'd0;
        job.term = i_in_last;
        if (r_mode == MODE_LATIN1) begin
            n_half   = 1'b0;
            job.unit = {8'h00, i_in_byte};
            job.len  = utf8_len(job.unit);
        end else if (!r_half) begin
            n_held = i_in_byte;
            n_half = 1'b1;
        end else begin
            n_half   = 1'b0;
            job.unit = r_big ? {r_held, i_in_byte} : {i_in_byte, r_held};
            job.len  = utf8_len(job.unit);
            if (r_first) begin
                n_first = 1'b0;
                if (r_held == BOM_FE && i_in_byte == BOM_FF) begin
                    n_big   = 1'b1;
                    job.len = 2'd0;
                end else if (r_held == BOM_FF && i_in_byte == BOM_FE) begin
                    n_big   = 1'b0;
                    job.len = 2'd0;
                end
            end
        end
        if (i_in_last) begin
            n_held  = 8'h00;
            n_half  = 1'b0;
            n_first = 1'b1;
            n_big   = 1'b0;
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.len != 2'd0 || job.term);

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 8'h00;
            r_half  <= 1'b0;
            r_first <= 1'b1;
            r_big   <= 1'b0;
        end else if (accept) begin
            r_held  <= n_held;
            r_half  <= n_half;
            r_first <= n_first;
            r_big   <= n_big;
        end
    end

endmodule

[rtl/ute_queue.sv]
module ute_queue import ute_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

[rtl/ute_back.sv]
module ute_back import ute_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_queue_empty,
    input  t_job       i_job,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_term,
    output logic       o_out_last
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_pos;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_term;
    logic       r_last;

    logic       out_load;
    logic       advance;
    logic       step_last;
    logic       step_term;
    logic [7:0] step_byte;
    logic       done;

    // current output byte of the job
    always_comb begin
        step_term = (r_pos == r_job.len);
        step_byte = step_term ? 8'h00 : utf8_byte(r_job.unit, r_job.len, r_pos);
        step_last = r_job.term ? step_term : (r_pos + 2'd1 == r_job.len);
    end

    assign out_load = !r_ov || !i_out_stall;
    assign advance  = r_busy && out_load;
    assign done     = advance && step_last;
    assign o_pop    = !i_queue_empty && (!r_busy || done);

    // job register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_pos  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_byte <= step_byte;
            r_term <= step_term;
            r_last <= step_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_out_term  = r_term;
    assign o_out_last  = r_last;

endmodule

[rtl/text_to_utf8_encoder.sv]
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_in_byte, i_end_of_text
// output    out        o_valid / i_stall         o_out_byte, o_is_terminator, o_run_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (source encoding)
//
// the front takes one byte a cycle while the two-entry queue has room
// the back emits one utf-8 byte a cycle while the output is not stalled, and one source byte
// gives zero to four results; the output port sets the sustained rate
// a request passes the queue, the job register and the output register before its first result shows
// synchronous active-low reset: ucs-2 mode, little-endian, string start
// a stalled output only holds its register; the front keeps going until the queue fills
module text_to_utf8_encoder import ute_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_terminator,
    output logic       o_run_last
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    assign o_cfg_ready = 1'b1;

    // classification
    ute_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_end_of_text),
        .i_queue_full (full),
        .o_in_stall   (o_stall),
        .o_push       (push),
        .o_job        (job_in)
    );

    // request queue
    ute_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // utf-8 byte emitter
    ute_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (empty),
        .i_job         (job_out),
        .o_pop         (pop),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_out_byte    (o_out_byte),
        .o_out_term    (o_is_terminator),
        .o_out_last    (o_run_last)
    );

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import ute_pkg::*;

    // one source byte as offered on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_src_byte;

    // one utf-8 byte as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       term;
        logic       last;
    } t_utf8_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_data = MODE_RESET;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_is_terminator;
    logic       o_run_last;

    // source bytes waiting to be offered, utf-8 bytes still owed by the block
    t_src_byte  src_q[$];
    t_utf8_byte utf8_q[$];
    int         errors = 0;
    int         rand_items = 0;

    // shadow of the mode register and the string decoder
    logic       enc_mode = MODE_RESET;
    logic [7:0] pair_byte = 8'h00;
    logic       pair_open = 1'b0;
    logic       string_start = 1'b1;
    logic       order_be = 1'b0;

    // sender burst shaping
    int         burst_left = 8;
    int         gap_left = 0;
    t_src_byte  nxt_src;

    // receiver stall pattern and the long hold-off
    logic       hold_req = 1'b0;
    logic       hold_done = 1'b0;
    int         hold_left = 0;
    int         seg_left = 0;
    int         stall_pct = 0;
    t_utf8_byte exp_byte;

    text_to_utf8_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_text   (i_end_of_text),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    // utf-8 bytes of one 16-bit code unit, returns the byte count
    function automatic int utf8_encode(input logic [15:0] u, output logic [7:0] b0,
                                       output logic [7:0] b1, output logic [7:0] b2);
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = 8'h00;
        if (u < LIMIT_ONE) begin
            b0 = u[7:0];
            return 1;
        end
        if (u < LIMIT_TWO) begin
            b0 = LEAD_TWO | {3'b000, u[10:6]};
            b1 = CONT_MARK | {2'b00, u[5:0] & CONT_MASK};
            return 2;
        end
        b0 = LEAD_THREE | {4'b0000, u[15:12]};
        b1 = CONT_MARK | {2'b00, u[11:6] & CONT_MASK};
        b2 = CONT_MARK | {2'b00, u[5:0] & CONT_MASK};
        return 3;
    endfunction

    // work out the utf-8 bytes owed for one accepted source byte
    task automatic predict_utf8(input logic [7:0] b, input logic eot);
        logic [7:0] ub [0:3];
        logic       ut [0:3];
        logic [7:0] first;
        logic       bom;
        int         n;
        t_utf8_byte r;
        n = 0;
        bom = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ub[i] = 8'h00;
            ut[i] = 1'b0;
        end
        if (enc_mode == MODE_LATIN1) begin
            // latin-1 drops any half pair but keeps the byte order
            pair_open = 1'b0;
            n = utf8_encode({8'h00, b}, ub[0], ub[1], ub[2]);
        end else if (!pair_open) begin
            pair_byte = b;
            pair_open = 1'b1;
        end else begin
            first = pair_byte;
            pair_open = 1'b0;
            if (string_start) begin
                string_start = 1'b0;
                if (first == BOM_FE && b == BOM_FF) begin
                    order_be = 1'b1;
                    bom = 1'b1;
                end else if (first == BOM_FF && b == BOM_FE) begin
                    order_be = 1'b0;
                    bom = 1'b1;
                end
            end
            if (!bom) begin
                n = utf8_encode(order_be ? {first, b} : {b, first}, ub[0], ub[1], ub[2]);
            end
        end
        // terminator and back to string start
        if (eot) begin
            ub[n] = 8'h00;
            ut[n] = 1'b1;
            n++;
            pair_byte = 8'h00;
            pair_open = 1'b0;
            string_start = 1'b1;
            order_be = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            r.data = ub[i];
            r.term = ut[i];
            r.last = (i == n - 1);
            utf8_q.push_back(r);
        end
    endtask

    task automatic queue_src(input logic [7:0] b, input logic eot);
        t_src_byte s;
        s.data = b;
        s.eot = eot;
        src_q.push_back(s);
    endtask

    // random code unit, biased toward range edges
    function automatic logic [15:0] rand_unit();
        logic [15:0] u;
        case ($urandom_range(4, 0))
            0: u = 16'($urandom_range(16'h007f, 0));
            1: u = 16'($urandom_range(16'h07ff, 16'h0080));
            2: u = 16'($urandom_range(16'hffff, 16'h0800));
            3: u = 16'($urandom);
            default: begin
                case ($urandom_range(8, 0))
                    0: u = 16'h0000;
                    1: u = 16'h007f;
                    2: u = 16'h0080;
                    3: u = 16'h07ff;
                    4: u = 16'h0800;
                    5: u = 16'hffff;
                    6: u = 16'hd800;
                    7: u = 16'hfeff;
                    default: u = 16'hfffe;
                endcase
            end
        endcase
        return u;
    endfunction

    // one random string; close low leaves it open for the next phase
    task automatic add_text(input logic mode, input logic close);
        t_src_byte   txt[$];
        t_src_byte   s;
        logic [15:0] u;
        int          n;
        int          bom_kind;
        logic        be;
        s.eot = 1'b0;
        if ($urandom_range(9, 0) < 2) begin
            // noise: one to six raw bytes
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) begin
                s.data = 8'($urandom_range(255, 0));
                txt.push_back(s);
            end
        end else if (mode == MODE_LATIN1) begin
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++) begin
                s.data = 8'($urandom_range(255, 0));
                txt.push_back(s);
            end
        end else begin
            bom_kind = $urandom_range(3, 0);
            be = (bom_kind == 1);
            if (bom_kind == 1) begin
                s.data = BOM_FE;
                txt.push_back(s);
                s.data = BOM_FF;
                txt.push_back(s);
            end else if (bom_kind == 2) begin
                s.data = BOM_FF;
                txt.push_back(s);
                s.data = BOM_FE;
                txt.push_back(s);
            end
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) begin
                u = rand_unit();
                s.data = be ? u[15:8] : u[7:0];
                txt.push_back(s);
                s.data = be ? u[7:0] : u[15:8];
                txt.push_back(s);
            end
            // dangling odd byte now and then
            if ($urandom_range(7, 0) == 0) begin
                s.data = 8'($urandom_range(255, 0));
                txt.push_back(s);
            end
        end
        s = txt.pop_back();
        s.eot = close;
        txt.push_back(s);
        rand_items += txt.size();
        foreach (txt[i]) src_q.push_back(txt[i]);
    endtask

    // wait for the block to drain, then let any zero-result request settle
    task automatic wait_idle();
        while (src_q.size() != 0 || i_valid || utf8_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        enc_mode = v;
    endtask

    // source request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_in_byte <= 8'h00;
            i_end_of_text <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_utf8(i_in_byte, i_end_of_text);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (src_q.size() > 0) begin
                    nxt_src = src_q.pop_front();
                    i_valid <= 1'b1;
                    i_in_byte <= nxt_src.data;
                    i_end_of_text <= nxt_src.eot;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(24, 1);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // utf-8 request monitor and stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (utf8_q.size() == 0) begin
                    $display("%0t: unexpected output byte, actual %h term %b last %b",
                             $time, o_out_byte, o_is_terminator, o_run_last);
                    errors++;
                end else begin
                    exp_byte = utf8_q.pop_front();
                    if (o_out_byte !== exp_byte.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp_byte.data, o_out_byte);
                        errors++;
                    end
                    if (o_is_terminator !== exp_byte.term) begin
                        $display("%0t: is_terminator expected %b actual %b",
                                 $time, exp_byte.term, o_is_terminator);
                        errors++;
                    end
                    if (o_run_last !== exp_byte.last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, exp_byte.last, o_run_last);
                        errors++;
                    end
                end
            end
            // one long hold-off while the sender keeps offering
            if (hold_req && !hold_done && i_valid) begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (seg_left <= 0) begin
                    seg_left = $urandom_range(40, 5);
                    case ($urandom_range(3, 0))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        2: stall_pct = 40;
                        default: stall_pct = 75;
                    endcase
                end
                seg_left--;
                i_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    // stimulus phases
    initial begin
        logic m;
        int   nstr;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_UCS2);

        // ucs-2: big-endian mark, one-, two- and three-byte units
        queue_src(8'hfe, 1'b0);
        queue_src(8'hff, 1'b0);
        queue_src(8'h00, 1'b0);
        queue_src(8'h41, 1'b0);
        queue_src(8'h07, 1'b0);
        queue_src(8'hff, 1'b0);
        queue_src(8'hff, 1'b0);
        queue_src(8'hff, 1'b1);
        // little-endian mark, embedded zero, dangling odd byte
        queue_src(8'hff, 1'b0);
        queue_src(8'hfe, 1'b0);
        queue_src(8'h00, 1'b0);
        queue_src(8'h00, 1'b0);
        queue_src(8'h80, 1'b0);
        queue_src(8'h00, 1'b0);
        queue_src(8'h5a, 1'b1);
        // no mark: default little-endian, four results from the last byte
        queue_src(8'h00, 1'b0);
        queue_src(8'h08, 1'b1);
        // big-endian mark then a held half pair left open
        queue_src(8'hfe, 1'b0);
        queue_src(8'hff, 1'b0);
        queue_src(8'h12, 1'b0);
        wait_idle();

        // latin-1 mid string drops the held byte
        write_mode(MODE_LATIN1);
        queue_src(8'h00, 1'b0);
        queue_src(8'h7f, 1'b0);
        queue_src(8'h80, 1'b0);
        queue_src(8'hff, 1'b0);
        wait_idle();

        // back to ucs-2, byte order from the mark still holds
        write_mode(MODE_UCS2);
        queue_src(8'h12, 1'b0);
        queue_src(8'h34, 1'b1);
        wait_idle();

        // random phases, some ending mid string
        while (rand_items < 400) begin
            m = 1'($urandom_range(1, 0));
            write_mode(m);
            nstr = $urandom_range(8, 2);
            for (int i = 0; i < nstr; i++) begin
                add_text(m, 1'b1);
            end
            if ($urandom_range(3, 0) == 0) begin
                add_text(m, 1'b0);
            end
            hold_req <= 1'b1;
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/ute_pkg.sv
rtl/ute_front.sv
rtl/ute_queue.sv
rtl/ute_back.sv
rtl/text_to_utf8_encoder.sv
tb/sv/tb_top.sv
